FILE: sv/rlfw_pkg.sv
// ----------------------------------------------------------------------------
// rlfw_pkg
// Shared types, codes and constants for the radio link failsafe watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package rlfw_pkg;

  // Default number of channels that must report good pulses
  localparam int unsigned REQUIRED_CHANNELS_DEF = 4;

  // Counter constants
  localparam logic [15:0] LOSS_MAX     = 16'hFFFF;
  localparam logic [15:0] SOFT_DROP    = 16'd20;
  localparam logic [9:0]  HOLD_RUNNING = 10'd300;
  localparam logic [9:0]  HOLD_3D      = 10'd1000;

  // Config register widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Item kinds
  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_PULSE  = 3'd1,
    KIND_UPDATE = 3'd2,
    KIND_RESET  = 3'd3,
    KIND_ENABLE = 3'd4
  } kind_t;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAND_THROTTLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_THROTTLE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_3D       = 3'd7;

  // Config reset values
  localparam logic [7:0]  RST_LOSS_DELAY    = 8'd10;
  localparam logic [7:0]  RST_OFF_DELAY     = 8'd200;
  localparam logic [10:0] RST_LAND_THROTTLE = 11'd1000;
  localparam logic [15:0] RST_PULSE_MIN     = 16'd985;
  localparam logic [15:0] RST_PULSE_MAX     = 16'd2115;
  localparam logic [10:0] RST_CENTER        = 11'd1500;
  localparam logic [10:0] RST_MIN_THROTTLE  = 11'd1150;
  localparam logic        RST_MODE_3D       = 1'b0;

  // Input item
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [15:0] pulse_usec;
    logic [10:0] throttle_cmd;
    logic        is_plane;
    logic        armed;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic        force_landing;
    logic [10:0] override_center;
    logic [10:0] override_throttle;
    logic        disarm;
    logic        link_idle;
    logic        timer_elapsed;
    logic        landing_overdue;
    logic [7:0]  event_count;
    logic        enabled;
  } out_item_t;

  // Configuration registers plus derived tick limits
  typedef struct packed {
    logic [10:0] landing_throttle;
    logic [15:0] pulse_min_usec;
    logic [15:0] pulse_max_usec;
    logic [10:0] center_value;
    logic [10:0] min_throttle;
    logic        mode_3d;
    logic [15:0] elapse_limit;   // 5 * loss_delay
    logic [15:0] overdue_limit;  // 5 * (loss_delay + off_delay)
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/radio_link_failsafe_watchdog_top.sv
// ----------------------------------------------------------------------------
// radio_link_failsafe_watchdog_top
// Radio link loss watchdog: input register, state update, result register.
// ----------------------------------------------------------------------------
//  Channel | Signals                              | Moves
//  --------+--------------------------------------+---------------------------
//  input   | in_valid, in_ready, in_item          | one item per transaction
//  result  | out_valid, out_ready, out_item       | one result per item
//  config  | cfg_valid, cfg_ready, cfg_index/data | one register write
//
//  One item per cycle sustained while out_ready stays high; an accepted item
//  passes through the input register, then the result register, where
//  out_valid rises with its result. The state update for an item is done in
//  the cycle it moves from the input register to the result register.
//  A stalled result holds the pipe; in_ready drops only when both stages are
//  full and out_ready is low. Reset is synchronous and restores register
//  defaults and clears all watchdog state. Config writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_link_failsafe_watchdog_top #(
  parameter int unsigned REQUIRED_CHANNELS = rlfw_pkg::REQUIRED_CHANNELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire rlfw_pkg::in_item_t              in_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output rlfw_pkg::out_item_t                  out_item,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rlfw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rlfw_pkg::CFG_DATA_W-1:0] cfg_data
);

  rlfw_pkg::cfg_t      cfg;
  rlfw_pkg::in_item_t  in_reg;
  rlfw_pkg::out_item_t result;
  logic                in_reg_valid;
  logic                advance;

  assign cfg_ready = 1'b1;

  rlfw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipe control
  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_reg <= in_item;
    end
  end

  rlfw_core #(
    .REQUIRED_CHANNELS (REQUIRED_CHANNELS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_reg_valid;
    end
    if (advance) begin
      out_item <= result;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rlfw_cfg.sv
// ----------------------------------------------------------------------------
// rlfw_cfg
// Configuration register file and derived guard-time limits in ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module rlfw_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  input  wire logic [rlfw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rlfw_pkg::CFG_DATA_W-1:0]    cfg_data,
  output rlfw_pkg::cfg_t                          cfg
);

  logic [7:0]  loss_delay;
  logic [7:0]  off_delay;
  logic [10:0] landing_throttle;
  logic [15:0] pulse_min_usec;
  logic [15:0] pulse_max_usec;
  logic [10:0] center_value;
  logic [10:0] min_throttle;
  logic        mode_3d;
  logic [11:0] delay_sum_x5;
  logic [8:0]  delay_sum;
  logic [10:0] loss_x5;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_delay       <= rlfw_pkg::RST_LOSS_DELAY;
      off_delay        <= rlfw_pkg::RST_OFF_DELAY;
      landing_throttle <= rlfw_pkg::RST_LAND_THROTTLE;
      pulse_min_usec   <= rlfw_pkg::RST_PULSE_MIN;
      pulse_max_usec   <= rlfw_pkg::RST_PULSE_MAX;
      center_value     <= rlfw_pkg::RST_CENTER;
      min_throttle     <= rlfw_pkg::RST_MIN_THROTTLE;
      mode_3d          <= rlfw_pkg::RST_MODE_3D;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rlfw_pkg::REG_LOSS_DELAY:    loss_delay       <= cfg_data[7:0];
        rlfw_pkg::REG_OFF_DELAY:     off_delay        <= cfg_data[7:0];
        rlfw_pkg::REG_LAND_THROTTLE: landing_throttle <= cfg_data[10:0];
        rlfw_pkg::REG_PULSE_MIN:     pulse_min_usec   <= cfg_data;
        rlfw_pkg::REG_PULSE_MAX:     pulse_max_usec   <= cfg_data;
        rlfw_pkg::REG_CENTER:        center_value     <= cfg_data[10:0];
        rlfw_pkg::REG_MIN_THROTTLE:  min_throttle     <= cfg_data[10:0];
        rlfw_pkg::REG_MODE_3D:       mode_3d          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Times five as shift and add
  assign loss_x5      = {1'b0, loss_delay, 2'b00} + {3'b000, loss_delay};
  assign delay_sum    = {1'b0, loss_delay} + {1'b0, off_delay};
  assign delay_sum_x5 = {1'b0, delay_sum, 2'b00} + {3'b000, delay_sum};

  always_comb begin
    cfg.landing_throttle = landing_throttle;
    cfg.pulse_min_usec   = pulse_min_usec;
    cfg.pulse_max_usec   = pulse_max_usec;
    cfg.center_value     = center_value;
    cfg.min_throttle     = min_throttle;
    cfg.mode_3d          = mode_3d;
    cfg.elapse_limit     = {5'b00000, loss_x5};
    cfg.overdue_limit    = {4'b0000, delay_sum_x5};
  end

endmodule

`default_nettype wire

FILE: sv/rlfw_core.sv
// ----------------------------------------------------------------------------
// rlfw_core
// Watchdog state and the per-item state update.
// ----------------------------------------------------------------------------
`default_nettype none

module rlfw_core #(
  parameter int unsigned REQUIRED_CHANNELS = rlfw_pkg::REQUIRED_CHANNELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire rlfw_pkg::in_item_t item,
  input  wire rlfw_pkg::cfg_t     cfg,
  output rlfw_pkg::out_item_t     result
);

  logic [15:0]                  loss_count, loss_count_next;
  logic [9:0]                   motor_hold, motor_hold_next;
  logic [REQUIRED_CHANNELS-1:0] good_mask, good_mask_next;
  logic [REQUIRED_CHANNELS-1:0] mask_set, mask_or;
  logic [7:0]                   landing_events, landing_events_next;
  logic                         active, active_next;
  logic                         pulse_ok, elapsed_pre, overdue_pre;
  logic                         land, disarm;

  assign elapsed_pre = loss_count > cfg.elapse_limit;
  assign overdue_pre = loss_count > cfg.overdue_limit;
  assign pulse_ok    = (item.pulse_usec > cfg.pulse_min_usec) &&
                       (item.pulse_usec < cfg.pulse_max_usec);

  // Channel bits to set for a good pulse
  always_comb begin
    for (int i = 0; i < REQUIRED_CHANNELS; i++) begin
      mask_set[i] = pulse_ok && (item.channel == 4'(i));
    end
  end
  assign mask_or = good_mask | mask_set;

  // Next state and command flags
  always_comb begin
    loss_count_next     = loss_count;
    motor_hold_next     = motor_hold;
    good_mask_next      = good_mask;
    landing_events_next = landing_events;
    active_next         = active;
    land                = 1'b0;
    disarm              = 1'b0;
    case (item.kind)
      rlfw_pkg::KIND_TICK: begin
        if (loss_count != rlfw_pkg::LOSS_MAX) begin
          loss_count_next = loss_count + 16'd1;
        end
        if (active && !item.is_plane) begin
          if (cfg.mode_3d) begin
            motor_hold_next = rlfw_pkg::HOLD_3D;
          end else if (item.throttle_cmd > cfg.min_throttle) begin
            motor_hold_next = rlfw_pkg::HOLD_RUNNING;
          end else if (motor_hold != 10'd0) begin
            motor_hold_next = motor_hold - 10'd1;
          end
        end
      end
      rlfw_pkg::KIND_PULSE: begin
        good_mask_next = mask_or;
        // all required channels seen: clear mask, back off the counter
        if (&mask_or) begin
          good_mask_next  = '0;
          loss_count_next = (loss_count > rlfw_pkg::SOFT_DROP) ?
                            loss_count - rlfw_pkg::SOFT_DROP : 16'd0;
        end
      end
      rlfw_pkg::KIND_UPDATE: begin
        if (elapsed_pre) begin
          if (!active) begin
            loss_count_next = 16'd0;
          end else begin
            if ((motor_hold != 10'd0) && item.armed) begin
              land                = 1'b1;
              landing_events_next = landing_events + 8'd1;
            end
            disarm = overdue_pre || !item.armed || (motor_hold == 10'd0);
          end
        end
      end
      rlfw_pkg::KIND_RESET:  loss_count_next = 16'd0;
      rlfw_pkg::KIND_ENABLE: active_next     = 1'b1;
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_count     <= '0;
      motor_hold     <= '0;
      good_mask      <= '0;
      landing_events <= '0;
      active         <= 1'b0;
    end else if (fire) begin
      loss_count     <= loss_count_next;
      motor_hold     <= motor_hold_next;
      good_mask      <= good_mask_next;
      landing_events <= landing_events_next;
      active         <= active_next;
    end
  end

  // Result fields, status taken after the item
  always_comb begin
    result.force_landing     = land;
    result.override_center   = land ? cfg.center_value : 11'd0;
    result.override_throttle = land ? cfg.landing_throttle : 11'd0;
    result.disarm            = disarm;
    result.link_idle         = loss_count_next <= 16'd1;
    result.timer_elapsed     = loss_count_next > cfg.elapse_limit;
    result.landing_overdue   = loss_count_next > cfg.overdue_limit;
    result.event_count       = landing_events_next;
    result.enabled           = active_next;
  end

endmodule

`default_nettype wire
